/* hdl/cmt_pkg.sv */
package cmt_pkg;

  localparam int TIME_W  = 32;
  localparam int MASK_W  = 12;
  localparam int CHAN_W  = 4;
  localparam int COUNT_W = 4;
  localparam int VAR_W   = 2;

  localparam int CH_TWELVE = 12;
  localparam int CH_FOUR   = 4;

  localparam logic [VAR_W-1:0] VAR_UNSET  = 2'd0;
  localparam logic [VAR_W-1:0] VAR_TWELVE = 2'd1;
  localparam logic [VAR_W-1:0] VAR_FOUR   = 2'd2;
  localparam logic [VAR_W-1:0] VAR_SPARE  = 2'd3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [TIME_W-1:0]   stamp_ms;
    logic [CHAN_W-1:0]   channel_index;
    logic [TIME_W-1:0]   duration_ms;
    logic [COUNT_W-1:0]  request_count;
  } cmt_in_t;

  typedef struct packed {
    logic [MASK_W-1:0]   channel_on_mask;
    logic [TIME_W-1:0]   longest_remaining_ms;
    logic                ready_res;
    logic                start_ignored;
  } cmt_out_t;

  typedef struct packed {
    logic valid;
    logic ignored;
    logic variant_set;
  } cmt_ctl_t;

endpackage

/* hdl/multi_channel_countdown_timers_unit.sv */
// Bank of millisecond countdown timers, one per channel; the board variant
// register selects twelve, four or no active channels, and changing it clears
// every timer. Each word on the input (a time tick or one element of a start
// request) yields one result word with the channel-on mask, the longest
// remaining time, the ready flag and the start-ignored flag. The block takes
// one word per cycle unless out_ready holds back the result register; each word
// passes through the input register, timer update, group maximum, final maximum
// and result register. Configuration writes are taken at any time and must only be
// issued while no word is in flight.
module multi_channel_countdown_timers_unit
  import cmt_pkg::*;
#(
  parameter int MAX_CHANNELS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmt_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cmt_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VAR_W-1:0]  cfg_data
);

  cmt_ctl_t                               ctl;
  logic [MAX_CHANNELS-1:0]                act;
  logic [MAX_CHANNELS-1:0][TIME_W-1:0]    timers;
  logic                                   take;

  assign cfg_ready = 1'b1;

  cmt_timer_bank #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .take      (take),
    .ctl       (ctl),
    .act       (act),
    .timers    (timers)
  );

  cmt_max_tree #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .act       (act),
    .timers    (timers),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/cmt_timer_bank.sv */
module cmt_timer_bank
  import cmt_pkg::*;
#(
  parameter int MAX_CHANNELS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  cmt_in_t                                in_data,
  input  logic                                   cfg_valid,
  input  logic [VAR_W-1:0]                       cfg_data,
  input  logic                                   take,
  output cmt_ctl_t                               ctl,
  output logic [MAX_CHANNELS-1:0]                act,
  output logic [MAX_CHANNELS-1:0][TIME_W-1:0]    timers
);

  localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
  localparam int CW         = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int ACT_TWELVE = (CH_TWELVE < MAX_CHANNELS) ? CH_TWELVE : MAX_CHANNELS;
  localparam int ACT_FOUR   = (CH_FOUR < MAX_CHANNELS) ? CH_FOUR : MAX_CHANNELS;

  cmt_in_t                                in_q;
  logic                                   v0;
  logic                                   v1;
  logic                                   ign1;
  logic [VAR_W-1:0]                       variant;
  logic [TIME_W-1:0]                      last_tick;
  logic [TIME_W-1:0]                      last_tick_next;
  logic [MAX_CHANNELS-1:0][TIME_W-1:0]    timers_next;
  logic                                   ign_next;
  logic                                   s1_load;
  logic [CW-1:0]                          active_cnt;
  logic [CW-1:0]                          count_x;
  logic [CW-1:0]                          chan_x;
  logic [TIME_W-1:0]                      elapsed;
  logic [VAR_W-1:0]                       cfg_norm;

  assign s1_load  = !v1 || take;
  assign in_ready = !v0 || s1_load;
  assign cfg_norm = (cfg_data == VAR_SPARE) ? VAR_UNSET : cfg_data;

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      act[i] = ((variant == VAR_TWELVE) && (i < ACT_TWELVE)) ||
               ((variant == VAR_FOUR) && (i < ACT_FOUR));
    end
  end

  always_comb begin
    unique case (variant)
      VAR_TWELVE: active_cnt = CW'(ACT_TWELVE);
      VAR_FOUR:   active_cnt = CW'(ACT_FOUR);
      default:    active_cnt = '0;
    endcase
  end

  assign count_x = CW'(in_q.request_count);
  assign chan_x  = CW'(in_q.channel_index);
  assign elapsed = in_q.stamp_ms - last_tick;

  always_comb begin
    timers_next    = timers;
    last_tick_next = last_tick;
    ign_next       = 1'b0;
    if (in_q.req_type == REQ_TICK) begin
      last_tick_next = in_q.stamp_ms;
      if (in_q.stamp_ms > last_tick) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          if (act[i]) begin
            timers_next[i] = (timers[i] > elapsed) ? (timers[i] - elapsed) : '0;
          end
        end
      end
    end else begin
      if (count_x > active_cnt) begin
        ign_next = 1'b1;
      end else if (count_x == '0) begin
        last_tick_next = in_q.stamp_ms;
      end else if (chan_x < count_x) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          if (CW'(i) == chan_x) begin
            timers_next[i] = in_q.duration_ms;
          end
        end
        if (chan_x == (count_x - CW'(1))) begin
          last_tick_next = in_q.stamp_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
    if (s1_load) begin
      ign1 <= ign_next && v0;
    end
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      variant   <= VAR_UNSET;
      last_tick <= '0;
      timers    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        v0 <= 1'b1;
      end else if (s1_load) begin
        v0 <= 1'b0;
      end
      if (s1_load) begin
        v1 <= v0;
        if (v0) begin
          timers    <= timers_next;
          last_tick <= last_tick_next;
        end
      end
      if (cfg_valid && (cfg_norm != variant)) begin
        variant <= cfg_norm;
        timers  <= '0;
      end
    end
  end

  assign ctl.valid       = v1;
  assign ctl.ignored     = ign1;
  assign ctl.variant_set = (variant != VAR_UNSET);

endmodule

/* hdl/cmt_max_tree.sv */
module cmt_max_tree
  import cmt_pkg::*;
#(
  parameter int MAX_CHANNELS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cmt_ctl_t                               ctl,
  input  logic [MAX_CHANNELS-1:0]                act,
  input  logic [MAX_CHANNELS-1:0][TIME_W-1:0]    timers,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output cmt_out_t                               out_data
);

  localparam int NG = (MAX_CHANNELS + 3) / 4;

  logic [NG*4-1:0][TIME_W-1:0]  padded;
  logic [NG-1:0][TIME_W-1:0]    gmax;
  logic [MASK_W-1:0]            on_mask;
  logic [NG-1:0][TIME_W-1:0]    s2_gmax;
  logic [MASK_W-1:0]            s2_mask;
  logic                         s2_ign;
  logic                         s2_valid;
  logic                         s2_set;
  logic                         out_load;
  logic [TIME_W-1:0]            longest;

  genvar gi;
  generate
    for (gi = 0; gi < NG * 4; gi++) begin : g_pad
      if (gi < MAX_CHANNELS) begin : g_real
        assign padded[gi] = act[gi] ? timers[gi] : '0;
      end else begin : g_zero
        assign padded[gi] = '0;
      end
    end
    for (gi = 0; gi < MASK_W; gi++) begin : g_mask
      if (gi < MAX_CHANNELS) begin : g_real
        assign on_mask[gi] = (padded[gi] != '0);
      end else begin : g_zero
        assign on_mask[gi] = 1'b0;
      end
    end
  endgenerate

  // first level: max within each group of four
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gmax[g] = padded[g*4];
      for (int k = 1; k < 4; k++) begin
        if (padded[g*4+k] > gmax[g]) begin
          gmax[g] = padded[g*4+k];
        end
      end
    end
  end

  always_comb begin
    longest = s2_gmax[0];
    for (int g = 1; g < NG; g++) begin
      if (s2_gmax[g] > longest) begin
        longest = s2_gmax[g];
      end
    end
  end

  assign out_load = !out_valid || out_ready;
  assign take     = !s2_valid || out_load;

  always_ff @(posedge clk) begin
    if (take) begin
      s2_gmax <= gmax;
      s2_mask <= on_mask;
      s2_ign  <= ctl.ignored;
      s2_set  <= ctl.variant_set;
    end
    if (out_load) begin
      out_data.channel_on_mask      <= s2_mask;
      out_data.longest_remaining_ms <= longest;
      out_data.ready_res            <= s2_set && (longest == '0);
      out_data.start_ignored        <= s2_ign;
    end
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s2_valid <= ctl.valid;
      end
      if (out_load) begin
        out_valid <= s2_valid;
      end
    end
  end

endmodule

/* tb/timer_bank_checker.sv */
module timer_bank_checker import cmt_pkg::*; #(
  parameter int MAX_CHANNELS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  cmt_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  cmt_out_t         out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [VAR_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TIME_W-1:0] timer_left [MAX_CHANNELS];
  logic [TIME_W-1:0] last_stamp;
  logic [VAR_W-1:0]  variant;
  cmt_out_t          expected_status [$];

  function automatic int live_channels(logic [VAR_W-1:0] v);
    int n;
    if (v == VAR_TWELVE) n = CH_TWELVE;
    else if (v == VAR_FOUR) n = CH_FOUR;
    else n = 0;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    return n;
  endfunction

  function automatic void clear_timers();
    for (int i = 0; i < MAX_CHANNELS; i++) timer_left[i] = '0;
  endfunction

  function automatic void set_variant(logic [VAR_W-1:0] v);
    logic [VAR_W-1:0] eff;
    eff = (v == VAR_SPARE) ? VAR_UNSET : v;
    if (eff != variant) begin
      clear_timers();
      variant = eff;
    end
  endfunction

  function automatic cmt_out_t advance_timers(cmt_in_t w);
    int                act;
    logic [TIME_W-1:0] elapsed;
    cmt_out_t          r;
    act = live_channels(variant);
    r = '0;
    if (w.req_type == REQ_TICK) begin
      if (w.stamp_ms <= last_stamp) begin
        last_stamp = w.stamp_ms;
      end else begin
        elapsed = w.stamp_ms - last_stamp;
        last_stamp = w.stamp_ms;
        for (int i = 0; i < act; i++)
          timer_left[i] = (timer_left[i] > elapsed) ? timer_left[i] - elapsed : '0;
      end
    end else if (int'(w.request_count) > act) begin
      r.start_ignored = 1'b1;
    end else if (w.request_count == 0) begin
      last_stamp = w.stamp_ms;
    end else if (w.channel_index < w.request_count) begin
      timer_left[w.channel_index] = w.duration_ms;
      if (int'(w.channel_index) == int'(w.request_count) - 1) last_stamp = w.stamp_ms;
    end
    for (int i = 0; i < act; i++) begin
      if (timer_left[i] != 0) begin
        if (i < MASK_W) r.channel_on_mask[i] = 1'b1;
        if (timer_left[i] > r.longest_remaining_ms) r.longest_remaining_ms = timer_left[i];
      end
    end
    r.ready_res = (variant != VAR_UNSET) && (r.longest_remaining_ms == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    cmt_out_t want;
    if (rst) begin
      clear_timers();
      last_stamp = '0;
      variant = VAR_UNSET;
      expected_status.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) set_variant(cfg_data);
      if (in_valid && in_ready) expected_status.push_back(advance_timers(in_data));
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.channel_on_mask !== want.channel_on_mask) begin
            $error("channel_on_mask: expected %h, got %h",
                   want.channel_on_mask, out_data.channel_on_mask);
            mismatches++;
          end
          if (out_data.longest_remaining_ms !== want.longest_remaining_ms) begin
            $error("longest_remaining_ms: expected %h, got %h",
                   want.longest_remaining_ms, out_data.longest_remaining_ms);
            mismatches++;
          end
          if (out_data.ready_res !== want.ready_res) begin
            $error("ready_res: expected %b, got %b", want.ready_res, out_data.ready_res);
            mismatches++;
          end
          if (out_data.start_ignored !== want.start_ignored) begin
            $error("start_ignored: expected %b, got %b",
                   want.start_ignored, out_data.start_ignored);
            mismatches++;
          end
        end
      end
      outstanding = expected_status.size();
    end
  end

endmodule

/* tb/multi_channel_countdown_timers_unit_tb.sv */
module multi_channel_countdown_timers_unit_tb import cmt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES  = 7;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  cmt_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  cmt_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VAR_W-1:0] cfg_data;

  int                mismatches;
  int                outstanding;
  bit                steady;
  bit                hold_off_req;
  logic [TIME_W-1:0] clock_ms;
  logic [VAR_W-1:0]  cur_variant;

  logic [VAR_W-1:0] phase_variant [NUM_PHASES] =
    '{VAR_TWELVE, VAR_FOUR, VAR_UNSET, VAR_TWELVE, VAR_SPARE, VAR_FOUR, VAR_TWELVE};

  multi_channel_countdown_timers_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  timer_bank_checker status_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return $urandom;
    if (r < 20) return '1;
    return $urandom_range(1, 400);
  endfunction

  function automatic cmt_in_t make_word(logic rt, logic [TIME_W-1:0] t,
                                        logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] dur,
                                        logic [COUNT_W-1:0] cnt);
    cmt_in_t w;
    w.req_type      = rt;
    w.stamp_ms      = t;
    w.channel_index = ch;
    w.duration_ms   = dur;
    w.request_count = cnt;
    return w;
  endfunction

  function automatic int request_span();
    if (cur_variant == VAR_TWELVE) return CH_TWELVE;
    return CH_FOUR;
  endfunction

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
    end
  end

  task automatic send_word(input cmt_in_t w);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic tick(input logic [TIME_W-1:0] t);
    send_word(make_word(REQ_TICK, t, '0, '0, '0));
  endtask

  task automatic start_elem(input logic [TIME_W-1:0] t, input int ch,
                            input logic [TIME_W-1:0] dur, input int cnt);
    send_word(make_word(REQ_START, t, CHAN_W'(ch), dur, COUNT_W'(cnt)));
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_variant(input logic [VAR_W-1:0] v);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_variant = v;
  endtask

  task automatic run_phase(input int n);
    int sent;
    int r;
    int cnt;
    int k;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 19) == 0) clock_ms = clock_ms - $urandom_range(1, 100);
        else if ($urandom_range(0, 4) != 0) clock_ms = clock_ms + $urandom_range(1, 60);
        send_word(make_word(REQ_TICK, clock_ms, CHAN_W'($urandom), $urandom,
                            COUNT_W'($urandom)));
        sent++;
      end else if (r < 78) begin
        // well-formed request: elements 0..cnt-1 at one time stamp
        cnt = $urandom_range(1, request_span());
        clock_ms = clock_ms + $urandom_range(0, 5);
        for (k = 0; k < cnt; k++) start_elem(clock_ms, k, pick_duration(), cnt);
        sent += cnt;
      end else if (r < 88) begin
        cnt = $urandom_range(0, 15);
        k = $urandom_range(1, 3);
        repeat (k) start_elem(clock_ms, $urandom_range(0, 15), pick_duration(), cnt);
        sent += k;
      end else begin
        send_word(make_word(1'($urandom), $urandom, CHAN_W'($urandom), $urandom,
                            COUNT_W'($urandom)));
        sent++;
      end
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = VAR_UNSET;
    steady = 1'b0;
    hold_off_req = 1'b0;
    clock_ms = '0;
    cur_variant = VAR_UNSET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no channels yet
    tick(32'd0);
    tick(32'd5);
    start_elem(32'd7, 0, 32'd10, 1);
    start_elem(32'd9, 0, 32'd10, 0);

    write_variant(VAR_TWELVE);
    start_elem(32'd100, 0, 32'hFFFF_FFFF, 2);
    start_elem(32'd100, 1, 32'd50, 2);
    tick(32'd130);
    tick(32'd130);
    tick(32'd120);
    tick(32'd200);
    start_elem(32'd250, 3, 32'd5, 15);
    start_elem(32'd300, 11, 32'd7, 12);
    start_elem(32'd310, 5, 32'd9, 3);
    start_elem(32'd320, 15, 32'd9, 12);
    tick(32'hFFFF_FFFF);

    write_variant(VAR_FOUR);
    start_elem(32'd10, 3, 32'd1, 4);
    start_elem(32'd12, 0, 32'd8, 5);
    tick(32'd20);
    start_elem(32'd30, 0, 32'd1000, 1);
    write_variant(VAR_FOUR);
    tick(32'd40);

    write_variant(VAR_SPARE);
    tick(32'd50);
    start_elem(32'd60, 0, 32'd10, 1);

    clock_ms = 32'd100;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_variant(phase_variant[p]);
      steady = (p == 1) || (p == 3);
      if (p == 1) hold_off_req = 1'b1;
      if (p == 0) begin
        run_phase(PHASE_ITEMS / 2);
        wait_drained();
        run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
    end
    steady = 1'b0;

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
